// ----- hw/rtl/differential_drive_command_shaper_top_defines.svh -----
// ---------------------------------------------------------------------------
// Command shaper assertion macros
// Shared property wrappers for the command shaper checks.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_COMMAND_SHAPER_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_COMMAND_SHAPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DDCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DDCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ddcs_pkg.sv -----
// ---------------------------------------------------------------------------
// Command shaper package
// Widths, register indexes, reset values and lane/merge config bundles.
// ---------------------------------------------------------------------------
package ddcs_pkg;

   localparam int CMD_WIDTH   = 16;
   localparam int REG_WIDTH   = 15;
   localparam int INDEX_WIDTH = 2;

   localparam logic [INDEX_WIDTH-1:0] CSR_MAX_COMMAND = 2'd0;
   localparam logic [INDEX_WIDTH-1:0] CSR_DEADBAND    = 2'd1;
   localparam logic [INDEX_WIDTH-1:0] CSR_DELTA_LIMIT = 2'd2;

   localparam logic [REG_WIDTH-1:0] MAX_COMMAND_RESET = 15'h7FFF;
   localparam logic [REG_WIDTH-1:0] DEADBAND_RESET    = 15'h0000;
   localparam logic [REG_WIDTH-1:0] DELTA_LIMIT_RESET = 15'h0000;

   typedef struct packed {
      logic [REG_WIDTH-1:0] max_command;
      logic [REG_WIDTH-1:0] deadband;
   } lane_cfg_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] max_command;
      logic [REG_WIDTH-1:0] delta_limit;
   } merge_cfg_type;

endpackage

// ----- hw/rtl/ddcs_lane.sv -----
// ---------------------------------------------------------------------------
// Command shaper lane
// Clamp one command to the symmetric bound, then apply the deadband bump.
// ---------------------------------------------------------------------------
module ddcs_lane (
   input  ddcs_pkg::lane_cfg_type              cfg,
   input  logic signed [ddcs_pkg::CMD_WIDTH-1:0] request,
   output logic signed [ddcs_pkg::CMD_WIDTH-1:0] shaped
);

   logic signed [ddcs_pkg::CMD_WIDTH:0] req_ext;
   logic signed [ddcs_pkg::CMD_WIDTH:0] bound;
   logic signed [ddcs_pkg::CMD_WIDTH:0] band;
   logic signed [ddcs_pkg::CMD_WIDTH:0] clamped;
   logic signed [ddcs_pkg::CMD_WIDTH:0] bumped;

   assign req_ext = {request[ddcs_pkg::CMD_WIDTH-1], request};
   assign bound   = signed'({2'b00, cfg.max_command});
   assign band    = signed'({2'b00, cfg.deadband});

   always_comb begin
      if (req_ext > bound) begin
         clamped = bound;
      end else if (req_ext < -bound) begin
         clamped = -bound;
      end else begin
         clamped = req_ext;
      end
   end

   // Raise small nonzero magnitudes to the deadband, keep the sign.
   always_comb begin
      if (clamped > 0 && clamped < band) begin
         bumped = band;
      end else if (clamped < 0 && clamped > -band) begin
         bumped = -band;
      end else begin
         bumped = clamped;
      end
   end

   assign shaped = bumped[ddcs_pkg::CMD_WIDTH-1:0];

endmodule

// ----- hw/rtl/ddcs_merge.sv -----
// ---------------------------------------------------------------------------
// Command shaper merge
// Limit the left/right spread, reclamp, and invert both for the driver.
// ---------------------------------------------------------------------------
module ddcs_merge (
   input  ddcs_pkg::merge_cfg_type               cfg,
   input  logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_shaped,
   input  logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_shaped,
   output logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_drive,
   output logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_drive
);

   localparam int W = ddcs_pkg::CMD_WIDTH + 1;

   logic signed [W-1:0] left_ext;
   logic signed [W-1:0] right_ext;
   logic signed [W-1:0] bound;
   logic signed [W-1:0] limit;
   logic signed [W-1:0] half;
   logic signed [W-1:0] delta;
   logic signed [W-1:0] sum;
   logic signed [W-1:0] sum_adj;
   logic signed [W-1:0] avg;
   logic signed [W-1:0] left_sel;
   logic signed [W-1:0] right_sel;
   logic signed [W-1:0] left_clip;
   logic signed [W-1:0] right_clip;
   logic signed [W-1:0] left_neg;
   logic signed [W-1:0] right_neg;
   logic                spread_hit;

   function automatic logic signed [W-1:0] clip(input logic signed [W-1:0] x,
                                                input logic signed [W-1:0] b);
      logic signed [W-1:0] r;
      if (x > b) begin
         r = b;
      end else if (x < -b) begin
         r = -b;
      end else begin
         r = x;
      end
      return r;
   endfunction

   assign left_ext  = {left_shaped[W-2], left_shaped};
   assign right_ext = {right_shaped[W-2], right_shaped};
   assign bound     = signed'({2'b00, cfg.max_command});
   assign limit     = signed'({2'b00, cfg.delta_limit});
   assign half      = signed'({3'b000, cfg.delta_limit[ddcs_pkg::REG_WIDTH-1:1]});

   assign delta = left_ext - right_ext;
   assign sum   = left_ext + right_ext;
   // Bias negative sums by one so the shift truncates toward zero.
   assign sum_adj = sum + signed'({{(W-1){1'b0}}, sum[W-1]});
   assign avg     = sum_adj >>> 1;

   assign spread_hit = (limit != 0) && (delta > limit || delta < -limit);

   always_comb begin
      if (!spread_hit) begin
         left_sel  = left_ext;
         right_sel = right_ext;
      end else if (delta > 0) begin
         left_sel  = avg + half;
         right_sel = avg - half;
      end else begin
         left_sel  = avg - half;
         right_sel = avg + half;
      end
   end

   // Reclamp only when the spread stage acted.
   assign left_clip  = spread_hit ? clip(left_sel, bound) : left_sel;
   assign right_clip = spread_hit ? clip(right_sel, bound) : right_sel;

   assign left_neg  = -left_clip;
   assign right_neg = -right_clip;

   assign left_drive  = left_neg[W-2:0];
   assign right_drive = right_neg[W-2:0];

endmodule

// ----- hw/rtl/differential_drive_command_shaper_top.sv -----
// ---------------------------------------------------------------------------
// Differential drive command shaper
// Two-lane shaping pipeline for left/right motor command pairs.
// ---------------------------------------------------------------------------
// Takes one item (a signed left/right command pair) per clock unless stalled
// and returns one shaped pair, sign-inverted for the motor driver, from the
// output register. Sustained rate is one item per cycle; the two pipeline
// registers (lane register, output register) set the latency, and rsp_stall backs up
// through req_stall only when both stages hold items. Two identical lanes
// clamp each command to +/- max_command and bump small nonzero values up to
// the deadband; the merge stage then sets the pair to its average +/- half of
// delta_limit when the spread exceeds delta_limit (zero disables it),
// reclamps, and negates. Write csr_* only while no item is in flight.
// ---------------------------------------------------------------------------
`include "differential_drive_command_shaper_top_defines.svh"

module differential_drive_command_shaper_top (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [ddcs_pkg::CMD_WIDTH-1:0]  req_left_request,
   input  logic signed [ddcs_pkg::CMD_WIDTH-1:0]  req_right_request,

   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [ddcs_pkg::CMD_WIDTH-1:0]  rsp_left_drive,
   output logic signed [ddcs_pkg::CMD_WIDTH-1:0]  rsp_right_drive,

   input  logic                                   csr_wr_en,
   input  logic [ddcs_pkg::INDEX_WIDTH-1:0]       csr_index,
   input  logic [ddcs_pkg::REG_WIDTH-1:0]         csr_wdata
);

   // Configuration registers
   logic [ddcs_pkg::REG_WIDTH-1:0] max_command_ff;
   logic [ddcs_pkg::REG_WIDTH-1:0] deadband_ff;
   logic [ddcs_pkg::REG_WIDTH-1:0] delta_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_command_ff <= ddcs_pkg::MAX_COMMAND_RESET;
         deadband_ff    <= ddcs_pkg::DEADBAND_RESET;
         delta_limit_ff <= ddcs_pkg::DELTA_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ddcs_pkg::CSR_MAX_COMMAND: max_command_ff <= csr_wdata;
            ddcs_pkg::CSR_DEADBAND:    deadband_ff    <= csr_wdata;
            ddcs_pkg::CSR_DELTA_LIMIT: delta_limit_ff <= csr_wdata;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   ddcs_pkg::lane_cfg_type  lane_cfg;
   ddcs_pkg::merge_cfg_type merge_cfg;

   assign lane_cfg.max_command  = max_command_ff;
   assign lane_cfg.deadband     = deadband_ff;
   assign merge_cfg.max_command = max_command_ff;
   assign merge_cfg.delta_limit = delta_limit_ff;

   // Flow control: a stage advances when it is empty or its successor moves.
   logic lane_valid_ff, lane_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_adv;
   logic lane_adv;
   logic req_take;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign lane_adv  = !lane_valid_ff || out_adv;
   assign req_stall = !lane_adv;
   assign req_take  = req_valid && lane_adv;

   assign lane_valid_in = lane_adv ? req_valid     : lane_valid_ff;
   assign out_valid_in  = out_adv  ? lane_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Lanes: clamp and deadband, one per motor.
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_lane;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_lane;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_lane_ff;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_lane_ff;

   ddcs_lane u_lane_left (
      .cfg     (lane_cfg),
      .request (req_left_request),
      .shaped  (left_lane)
   );

   ddcs_lane u_lane_right (
      .cfg     (lane_cfg),
      .request (req_right_request),
      .shaped  (right_lane)
   );

   // Hold lane results while the output stage is blocked.
   always_ff @(posedge clock) begin
      if (req_take) begin
         left_lane_ff  <= left_lane;
         right_lane_ff <= right_lane;
      end
   end

   // Merge: spread limit, reclamp, invert.
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_merged;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_merged;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] left_drive_ff;
   logic signed [ddcs_pkg::CMD_WIDTH-1:0] right_drive_ff;

   ddcs_merge u_merge (
      .cfg          (merge_cfg),
      .left_shaped  (left_lane_ff),
      .right_shaped (right_lane_ff),
      .left_drive   (left_merged),
      .right_drive  (right_merged)
   );

   // Advance the output register only when a lane item moves in.
   always_ff @(posedge clock) begin
      if (out_adv && lane_valid_ff) begin
         left_drive_ff  <= left_merged;
         right_drive_ff <= right_merged;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_left_drive  = left_drive_ff;
   assign rsp_right_drive = right_drive_ff;

   // Every output stays within the symmetric range; the most negative code
   // would mean a clamp was skipped.
   `DDCS_ASSERT_NOW(a_drive_range, clock, reset, rsp_valid,
      (rsp_left_drive != 16'sh8000) && (rsp_right_drive != 16'sh8000),
      "drive output left the symmetric range")

   // An accepted item always lands in the lane register.
   `DDCS_ASSERT_NEXT(a_take_lands, clock, reset, req_valid && !req_stall,
      lane_valid_ff, "accepted item missing from lane stage")

   // A lane item blocked by a stalled output is kept, not lost.
   `DDCS_ASSERT_NEXT(a_lane_held, clock, reset, lane_valid_ff && !out_adv,
      lane_valid_ff && out_valid_ff, "lane item dropped under stall")

endmodule
